// ===== sv/ssm_pkg.sv =====
// shared types and operation codes for the sparse set id map
package ssm_pkg;

    // operation codes carried by the mode field
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_GET_ID = 3'd4;

    // command to one single-ported memory
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_op_t;

    // one result beat
    typedef struct packed {
        logic        ok;
        logic [7:0]  out_id;
        logic [7:0]  out_position;
        logic [31:0] payload_out;
        logic [8:0]  live_count;
    } result_t;

endpackage

// ===== sv/ssm_tables.sv =====
// id-to-position and position-to-id tables with identity fill after reset
module ssm_tables #(
    parameter int ENTRIES = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ssm_pkg::mem_op_t         i2p_op,
    input  logic [$clog2(ENTRIES)-1:0] i2p_addr,
    input  logic [$clog2(ENTRIES)-1:0] i2p_wdata,
    output logic [$clog2(ENTRIES)-1:0] i2p_rdata,
    input  ssm_pkg::mem_op_t         p2i_op,
    input  logic [$clog2(ENTRIES)-1:0] p2i_addr,
    input  logic [$clog2(ENTRIES)-1:0] p2i_wdata,
    output logic [$clog2(ENTRIES)-1:0] p2i_rdata,
    output logic                     init_done
);
    localparam int IDX_W = $clog2(ENTRIES);

    logic [IDX_W-1:0] i2p_mem [ENTRIES];
    logic [IDX_W-1:0] p2i_mem [ENTRIES];
    logic [IDX_W-1:0] i2p_rdata_reg;
    logic [IDX_W-1:0] p2i_rdata_reg;
    logic             init_busy_reg;
    logic [IDX_W-1:0] init_idx_reg;

    // identity sweep, one entry of each table per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_busy_reg <= 1'b1;
            init_idx_reg  <= '0;
        end else if (init_busy_reg) begin
            init_idx_reg <= init_idx_reg + 1'b1;
            if (init_idx_reg == IDX_W'(ENTRIES - 1)) begin
                init_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (init_busy_reg) begin
            i2p_mem[init_idx_reg] <= init_idx_reg;
        end else if (i2p_op.wr) begin
            i2p_mem[i2p_addr] <= i2p_wdata;
        end
        if (i2p_op.rd) begin
            i2p_rdata_reg <= i2p_mem[i2p_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (init_busy_reg) begin
            p2i_mem[init_idx_reg] <= init_idx_reg;
        end else if (p2i_op.wr) begin
            p2i_mem[p2i_addr] <= p2i_wdata;
        end
        if (p2i_op.rd) begin
            p2i_rdata_reg <= p2i_mem[p2i_addr];
        end
    end

    assign i2p_rdata = i2p_rdata_reg;
    assign p2i_rdata = p2i_rdata_reg;
    assign init_done = !init_busy_reg;

endmodule

// ===== sv/ssm_payload.sv =====
// packed payload store, single port, registered read
module ssm_payload #(
    parameter int ENTRIES      = 256,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       aclk,
    input  ssm_pkg::mem_op_t           pay_op,
    input  logic [$clog2(ENTRIES)-1:0] pay_addr,
    input  logic [PAYLOAD_BITS-1:0]    pay_wdata,
    output logic [PAYLOAD_BITS-1:0]    pay_rdata
);
    logic [PAYLOAD_BITS-1:0] pay_mem [ENTRIES];
    logic [PAYLOAD_BITS-1:0] pay_rdata_reg;

    always_ff @(posedge aclk) begin
        if (pay_op.wr) begin
            pay_mem[pay_addr] <= pay_wdata;
        end
        if (pay_op.rd) begin
            pay_rdata_reg <= pay_mem[pay_addr];
        end
    end

    assign pay_rdata = pay_rdata_reg;

endmodule

// ===== sv/ssm_ctrl.sv =====
// operation sequencer: reads the tables, decides, writes back
module ssm_ctrl #(
    parameter int ENTRIES      = 256,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 mode,
    input  logic [7:0]                 entry_id,
    input  logic [7:0]                 slot_position,
    input  logic [31:0]                payload_in,
    input  logic                       init_done,
    input  logic                       out_free,
    output logic                       done,
    output ssm_pkg::result_t           result,
    output ssm_pkg::mem_op_t           i2p_op,
    output logic [$clog2(ENTRIES)-1:0] i2p_addr,
    output logic [$clog2(ENTRIES)-1:0] i2p_wdata,
    input  logic [$clog2(ENTRIES)-1:0] i2p_rdata,
    output ssm_pkg::mem_op_t           p2i_op,
    output logic [$clog2(ENTRIES)-1:0] p2i_addr,
    output logic [$clog2(ENTRIES)-1:0] p2i_wdata,
    input  logic [$clog2(ENTRIES)-1:0] p2i_rdata,
    output ssm_pkg::mem_op_t           pay_op,
    output logic [$clog2(ENTRIES)-1:0] pay_addr,
    output logic [PAYLOAD_BITS-1:0]    pay_wdata,
    input  logic [PAYLOAD_BITS-1:0]    pay_rdata
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_EV   = 6'b000100,
        ST_WR1  = 6'b001000,
        ST_WR2  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t           state_reg;
    logic [2:0]       mode_reg;
    logic [7:0]       id_reg;
    logic [7:0]       slot_reg;
    logic [31:0]      pay_in_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pid_reg;
    logic [IDX_W-1:0] a_pos_reg;
    logic             res_ok_reg;
    logic [7:0]       res_id_reg;
    logic [7:0]       res_pos_reg;
    logic [31:0]      res_pay_reg;

    logic [IDX_W-1:0] id_idx;
    logic             id_in_range;
    logic             pos_live;
    logic             not_full;
    logic             slot_live;
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] np;
    logic             ev_ok;
    logic             ev_more;

    assign id_idx      = IDX_W'(id_reg);
    assign id_in_range = 32'(id_reg) < 32'(ENTRIES);
    assign pos_live    = CNT_W'(i2p_rdata) < occ_reg;
    assign not_full    = occ_reg < CNT_W'(ENTRIES);
    assign slot_live   = 32'(slot_reg) < 32'(occ_reg);
    assign last        = IDX_W'(occ_reg - CNT_W'(1));
    assign np          = IDX_W'(occ_reg);

    always_comb begin
        ev_ok   = 1'b0;
        ev_more = 1'b0;
        unique case (mode_reg)
            ssm_pkg::MODE_ADD: begin
                ev_ok = not_full;
            end
            ssm_pkg::MODE_REMOVE: begin
                ev_ok   = id_in_range && pos_live;
                ev_more = ev_ok && (last != i2p_rdata);
            end
            ssm_pkg::MODE_INSERT: begin
                ev_ok   = id_in_range && !pos_live && not_full;
                ev_more = ev_ok;
            end
            ssm_pkg::MODE_GET: begin
                ev_ok   = id_in_range && pos_live;
                ev_more = ev_ok;
            end
            ssm_pkg::MODE_GET_ID: begin
                ev_ok = slot_live;
            end
            default: begin
                ev_ok = 1'b0;
            end
        endcase
    end

    // memory commands per step
    always_comb begin
        i2p_op    = '0;
        i2p_addr  = id_idx;
        i2p_wdata = a_pos_reg;
        p2i_op    = '0;
        p2i_addr  = np;
        p2i_wdata = id_idx;
        pay_op    = '0;
        pay_addr  = np;
        pay_wdata = PAYLOAD_BITS'(pay_in_reg);
        unique case (state_reg)
            ST_RD: begin
                i2p_op.rd = 1'b1;
                p2i_op.rd = 1'b1;
                if (mode_reg == ssm_pkg::MODE_GET_ID) begin
                    p2i_addr = IDX_W'(slot_reg);
                end else if (mode_reg == ssm_pkg::MODE_REMOVE) begin
                    p2i_addr = last;
                end
            end
            ST_EV: begin
                if (ev_ok) begin
                    if (mode_reg == ssm_pkg::MODE_ADD || mode_reg == ssm_pkg::MODE_INSERT) begin
                        pay_op.wr = 1'b1;
                    end else if (mode_reg == ssm_pkg::MODE_GET) begin
                        pay_op.rd = 1'b1;
                        pay_addr  = i2p_rdata;
                    end else if (ev_more) begin
                        // remove: fetch the last payload to move into the hole
                        pay_op.rd = 1'b1;
                        pay_addr  = last;
                    end
                end
            end
            ST_WR1: begin
                if (mode_reg != ssm_pkg::MODE_GET) begin
                    i2p_op.wr = 1'b1;
                    p2i_op.wr = 1'b1;
                    p2i_addr  = a_pos_reg;
                end
                if (mode_reg == ssm_pkg::MODE_REMOVE) begin
                    pay_op.wr = 1'b1;
                    pay_addr  = pos_reg;
                    pay_wdata = pay_rdata;
                end
            end
            ST_WR2: begin
                // the other id takes the position the first one left
                i2p_op.wr = 1'b1;
                i2p_addr  = pid_reg;
                i2p_wdata = pos_reg;
                p2i_op.wr = 1'b1;
                p2i_addr  = pos_reg;
                p2i_wdata = pid_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && init_done) begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_EV;
                end
                ST_EV: begin
                    if (ev_ok) begin
                        if (mode_reg == ssm_pkg::MODE_ADD || mode_reg == ssm_pkg::MODE_INSERT) begin
                            occ_reg <= occ_reg + CNT_W'(1);
                        end else if (mode_reg == ssm_pkg::MODE_REMOVE) begin
                            occ_reg <= occ_reg - CNT_W'(1);
                        end
                    end
                    state_reg <= ev_more ? ST_WR1 : ST_DONE;
                end
                ST_WR1: begin
                    state_reg <= (mode_reg == ssm_pkg::MODE_GET) ? ST_DONE : ST_WR2;
                end
                ST_WR2: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item and result registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && init_done) begin
            mode_reg   <= mode;
            id_reg     <= entry_id;
            slot_reg   <= slot_position;
            pay_in_reg <= payload_in;
        end
        if (state_reg == ST_EV) begin
            pos_reg     <= i2p_rdata;
            pid_reg     <= p2i_rdata;
            a_pos_reg   <= (mode_reg == ssm_pkg::MODE_REMOVE) ? last : np;
            res_ok_reg  <= ev_ok;
            res_id_reg  <= (ev_ok && (mode_reg == ssm_pkg::MODE_ADD ||
                            mode_reg == ssm_pkg::MODE_GET_ID)) ? 8'(p2i_rdata) : 8'd0;
            res_pos_reg <= (ev_ok && mode_reg == ssm_pkg::MODE_GET) ? 8'(i2p_rdata) : 8'd0;
            res_pay_reg <= '0;
        end
        if (state_reg == ST_WR1 && mode_reg == ssm_pkg::MODE_GET) begin
            res_pay_reg <= 32'(pay_rdata);
        end
    end

    assign s_ready             = (state_reg == ST_IDLE) && init_done;
    assign done                = (state_reg == ST_DONE) && out_free;
    assign result.ok           = res_ok_reg;
    assign result.out_id       = res_id_reg;
    assign result.out_position = res_pos_reg;
    assign result.payload_out  = res_pay_reg;
    assign result.live_count   = 9'(occ_reg);

endmodule

// ===== sv/sparse_set_id_map.sv =====
// sparse set id map top level: sequencer, tables, payload store, result register
// Sparse set mapping stable ids to a packed payload array, one operation per input
// beat (add, remove, insert at id, get by id, id at position), one result beat each.
// The state lives in three single-ported memories with registered reads, so an item
// is worked one at a time: add, id-at-position and any failed operation pass through
// the read, evaluate and done steps, get also waits for its payload read, and a
// remove that moves the last entry or an insert adds the write steps set by the
// two dependent table writes per port. A finished result sits in an output register,
// so a stalled m_ready holds the sequencer only at its last step. After reset both
// tables are filled with identity, one entry per cycle; s_ready stays low until done.
module sparse_set_id_map #(
    parameter int ENTRIES      = 256,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_entry_id,
    input  logic [7:0]  s_slot_position,
    input  logic [31:0] s_payload_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [7:0]  m_out_id,
    output logic [7:0]  m_out_position,
    output logic [31:0] m_payload_out,
    output logic [8:0]  m_live_count
);
    localparam int IDX_W = $clog2(ENTRIES);

    ssm_pkg::mem_op_t        i2p_op;
    ssm_pkg::mem_op_t        p2i_op;
    ssm_pkg::mem_op_t        pay_op;
    logic [IDX_W-1:0]        i2p_addr;
    logic [IDX_W-1:0]        i2p_wdata;
    logic [IDX_W-1:0]        i2p_rdata;
    logic [IDX_W-1:0]        p2i_addr;
    logic [IDX_W-1:0]        p2i_wdata;
    logic [IDX_W-1:0]        p2i_rdata;
    logic [IDX_W-1:0]        pay_addr;
    logic [PAYLOAD_BITS-1:0] pay_wdata;
    logic [PAYLOAD_BITS-1:0] pay_rdata;
    logic                    init_done;
    logic                    out_free;
    logic                    done;
    ssm_pkg::result_t        result;
    ssm_pkg::result_t        out_reg;
    logic                    m_valid_reg;

    assign out_free = !m_valid_reg || m_ready;

    ssm_ctrl #(
        .ENTRIES      (ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .mode          (s_mode),
        .entry_id      (s_entry_id),
        .slot_position (s_slot_position),
        .payload_in    (s_payload_in),
        .init_done     (init_done),
        .out_free      (out_free),
        .done          (done),
        .result        (result),
        .i2p_op        (i2p_op),
        .i2p_addr      (i2p_addr),
        .i2p_wdata     (i2p_wdata),
        .i2p_rdata     (i2p_rdata),
        .p2i_op        (p2i_op),
        .p2i_addr      (p2i_addr),
        .p2i_wdata     (p2i_wdata),
        .p2i_rdata     (p2i_rdata),
        .pay_op        (pay_op),
        .pay_addr      (pay_addr),
        .pay_wdata     (pay_wdata),
        .pay_rdata     (pay_rdata)
    );

    ssm_tables #(
        .ENTRIES (ENTRIES)
    ) u_tables (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .i2p_op    (i2p_op),
        .i2p_addr  (i2p_addr),
        .i2p_wdata (i2p_wdata),
        .i2p_rdata (i2p_rdata),
        .p2i_op    (p2i_op),
        .p2i_addr  (p2i_addr),
        .p2i_wdata (p2i_wdata),
        .p2i_rdata (p2i_rdata),
        .init_done (init_done)
    );

    ssm_payload #(
        .ENTRIES      (ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_payload (
        .aclk      (aclk),
        .pay_op    (pay_op),
        .pay_addr  (pay_addr),
        .pay_wdata (pay_wdata),
        .pay_rdata (pay_rdata)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            out_reg <= result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = out_reg.ok;
    assign m_out_id       = out_reg.out_id;
    assign m_out_position = out_reg.out_position;
    assign m_payload_out  = out_reg.payload_out;
    assign m_live_count   = out_reg.live_count;

endmodule

// ===== sim/ssm_result_checker.sv =====
// result checker for the sparse set id map: predicts each result beat and compares it
module ssm_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_entry_id,
    input  logic [7:0]  s_slot_position,
    input  logic [31:0] s_payload_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_ok,
    input  logic [7:0]  m_out_id,
    input  logic [7:0]  m_out_position,
    input  logic [31:0] m_payload_out,
    input  logic [8:0]  m_live_count,
    output int          mismatches,
    output int          awaiting
);

    logic [7:0]       id_to_slot [256];
    logic [7:0]       slot_to_id [256];
    logic [31:0]      stored_payload [256];
    logic [8:0]       live;
    int               fails;
    ssm_pkg::result_t due_results [$];

    // applies one operation to the shadow tables and returns the beat it should give
    function automatic ssm_pkg::result_t apply_op(input logic [2:0] op, input logic [7:0] id,
                                                  input logic [7:0] slot,
                                                  input logic [31:0] payload);
        ssm_pkg::result_t r;
        logic [7:0]       pos;
        logic [7:0]       last;
        logic [7:0]       last_id;
        logic [7:0]       fresh;
        logic [7:0]       displaced;
        logic [31:0]      held;
        r = '0;
        pos = id_to_slot[id];
        case (op)
            ssm_pkg::MODE_ADD: begin
                if (live < 9'd256) begin
                    fresh = live[7:0];
                    stored_payload[fresh] = payload;
                    r.out_id = slot_to_id[fresh];
                    live = live + 9'd1;
                    r.ok = 1'b1;
                end
            end
            ssm_pkg::MODE_REMOVE: begin
                if ({1'b0, pos} < live) begin
                    last = 8'(live - 9'd1);
                    last_id = slot_to_id[last];
                    live = live - 9'd1;
                    // last live entry moves into the freed slot
                    if (last != pos) begin
                        held = stored_payload[pos];
                        stored_payload[pos] = stored_payload[last];
                        stored_payload[last] = held;
                        slot_to_id[last] = id;
                        slot_to_id[pos] = last_id;
                        id_to_slot[id] = last;
                        id_to_slot[last_id] = pos;
                    end
                    r.ok = 1'b1;
                end
            end
            ssm_pkg::MODE_INSERT: begin
                if ({1'b0, pos} >= live && live < 9'd256) begin
                    fresh = live[7:0];
                    live = live + 9'd1;
                    displaced = slot_to_id[fresh];
                    stored_payload[fresh] = payload;
                    id_to_slot[id] = fresh;
                    slot_to_id[fresh] = id;
                    id_to_slot[displaced] = pos;
                    slot_to_id[pos] = displaced;
                    r.ok = 1'b1;
                end
            end
            ssm_pkg::MODE_GET: begin
                if ({1'b0, pos} < live) begin
                    r.out_position = pos;
                    r.payload_out = stored_payload[pos];
                    r.ok = 1'b1;
                end
            end
            ssm_pkg::MODE_GET_ID: begin
                if ({1'b0, slot} < live) begin
                    r.out_id = slot_to_id[slot];
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.live_count = live;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        ssm_pkg::result_t want;
        ssm_pkg::result_t got;
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) begin
                id_to_slot[i] = 8'(i);
                slot_to_id[i] = 8'(i);
                stored_payload[i] = '0;
            end
            live = '0;
            fails = 0;
            due_results.delete();
            mismatches <= 0;
            awaiting <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_ok, m_out_id, m_out_position, m_payload_out, m_live_count};
                if (due_results.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("result beat with nothing outstanding: %s%0d %0d %0d %h %0d",
                                 "ok/id/pos/pay/live ", got.ok, got.out_id,
                                 got.out_position, got.payload_out, got.live_count);
                end else begin
                    want = due_results.pop_front();
                    if (got.ok !== want.ok || got.out_id !== want.out_id
                            || got.out_position !== want.out_position
                            || got.payload_out !== want.payload_out
                            || got.live_count !== want.live_count) begin
                        fails = fails + 1;
                        if (fails <= 10) begin
                            $display("mismatch expected ok=%0d id=%0d pos=%0d pay=%h live=%0d",
                                     want.ok, want.out_id, want.out_position,
                                     want.payload_out, want.live_count);
                            $display("         actual   ok=%0d id=%0d pos=%0d pay=%h live=%0d",
                                     got.ok, got.out_id, got.out_position,
                                     got.payload_out, got.live_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                due_results.push_back(apply_op(s_mode, s_entry_id, s_slot_position,
                                               s_payload_in));
            mismatches <= fails;
            awaiting <= due_results.size();
        end
    end

endmodule

// ===== sim/tb_sparse_set_id_map.sv =====
// testbench top for the sparse set id map: stimulus, stalls, watchdog and verdict
module tb_sparse_set_id_map;

    // modes the block does not implement
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam int QUIET_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode = ssm_pkg::MODE_ADD;
    logic [7:0]  s_entry_id = '0;
    logic [7:0]  s_slot_position = '0;
    logic [31:0] s_payload_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [7:0]  m_out_id;
    logic [7:0]  m_out_position;
    logic [31:0] m_payload_out;
    logic [8:0]  m_live_count;
    logic        steady = 1'b0;
    int          mismatches;
    int          awaiting;
    int          quiet = 0;

    always #1 aclk = ~aclk;

    sparse_set_id_map dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_entry_id      (s_entry_id),
        .s_slot_position (s_slot_position),
        .s_payload_in    (s_payload_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_out_id        (m_out_id),
        .m_out_position  (m_out_position),
        .m_payload_out   (m_payload_out),
        .m_live_count    (m_live_count)
    );

    ssm_result_checker ssm_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_entry_id      (s_entry_id),
        .s_slot_position (s_slot_position),
        .s_payload_in    (s_payload_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_out_id        (m_out_id),
        .m_out_position  (m_out_position),
        .m_payload_out   (m_payload_out),
        .m_live_count    (m_live_count),
        .mismatches      (mismatches),
        .awaiting        (awaiting)
    );

    always @(posedge aclk)
        m_ready <= steady || ($urandom_range(99) >= 28);

    // watchdog: cycles in which no beat moves on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("sparse_set_id_map test failed");
                $finish;
            end
        end
    end

    task automatic issue_op(input logic [2:0] op, input logic [7:0] id,
                            input logic [7:0] slot, input logic [31:0] payload);
        if (!steady && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 28);
        end
        s_valid <= 1'b1;
        s_mode <= op;
        s_entry_id <= id;
        s_slot_position <= slot;
        s_payload_in <= payload;
        do @(posedge aclk); while (!s_ready);
    endtask

    // weights are out of a hundred; what is left goes to id-at-position and bad modes
    task automatic random_op(input int w_add, input int w_rem, input int w_ins, input int w_get);
        int         roll;
        logic [2:0] op;
        logic [7:0] slot;
        roll = $urandom_range(99);
        if (roll < w_add)
            op = ssm_pkg::MODE_ADD;
        else if (roll < w_add + w_rem)
            op = ssm_pkg::MODE_REMOVE;
        else if (roll < w_add + w_rem + w_ins)
            op = ssm_pkg::MODE_INSERT;
        else if (roll < w_add + w_rem + w_ins + w_get)
            op = ssm_pkg::MODE_GET;
        else if (roll < 98)
            op = ssm_pkg::MODE_GET_ID;
        else begin
            case ($urandom_range(2))
                0: op = MODE_SPARE_5;
                1: op = MODE_SPARE_6;
                default: op = MODE_SPARE_7;
            endcase
        end
        // low positions are live far more often
        slot = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(31));
        issue_op(op, 8'($urandom_range(255)), slot, $urandom);
    endtask

    initial begin : stimulus
        logic [7:0] base;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, free ids and unknown modes
        issue_op(ssm_pkg::MODE_GET, 8'd0, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_GET_ID, 8'd0, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_REMOVE, 8'd7, 8'd0, 32'd0);
        issue_op(MODE_SPARE_5, 8'd0, 8'd0, 32'd0);
        issue_op(MODE_SPARE_6, 8'h55, 8'haa, 32'h1234_5678);
        issue_op(MODE_SPARE_7, 8'hff, 8'hff, 32'hffff_ffff);
        // a few adds, then insert at the top id and at a live id
        issue_op(ssm_pkg::MODE_ADD, 8'hff, 8'hff, 32'h0000_0000);
        issue_op(ssm_pkg::MODE_ADD, 8'd0, 8'd0, 32'hffff_ffff);
        issue_op(ssm_pkg::MODE_ADD, 8'd0, 8'd0, 32'ha5a5_a5a5);
        issue_op(ssm_pkg::MODE_INSERT, 8'hff, 8'd0, 32'h1234_5678);
        issue_op(ssm_pkg::MODE_INSERT, 8'd1, 8'd0, 32'hdead_beef);
        issue_op(ssm_pkg::MODE_GET, 8'hff, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_GET, 8'd0, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_GET_ID, 8'd0, 8'd3, 32'd0);
        issue_op(ssm_pkg::MODE_GET_ID, 8'd0, 8'd4, 32'd0);
        issue_op(ssm_pkg::MODE_GET_ID, 8'd0, 8'hff, 32'd0);
        // remove from the middle moves the last entry, remove of the last does not
        issue_op(ssm_pkg::MODE_REMOVE, 8'd0, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_GET, 8'hff, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_REMOVE, 8'd2, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_GET, 8'd2, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_INSERT, 8'd0, 8'd0, 32'h0f0f_0f0f);
        issue_op(ssm_pkg::MODE_ADD, 8'd0, 8'd0, 32'h5a5a_5a5a);
        issue_op(ssm_pkg::MODE_GET, 8'd0, 8'd0, 32'd0);
        issue_op(ssm_pkg::MODE_GET_ID, 8'd0, 8'd2, 32'd0);

        // fill until the table is full and adds start to bounce
        repeat (520) random_op(55, 6, 20, 10);

        // sweep every id with remove so the table drains to empty, no stalls
        steady <= 1'b1;
        base = 8'($urandom_range(255));
        for (int k = 0; k < 256; k++) begin
            if ($urandom_range(99) < 30)
                random_op(0, 0, 0, 50);
            issue_op(ssm_pkg::MODE_REMOVE, base + 8'(k), 8'($urandom_range(255)), $urandom);
        end
        steady <= 1'b0;

        // mixed traffic around a moving fill level
        repeat (360) random_op(25, 25, 25, 12);

        s_valid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("sparse_set_id_map test passed");
        else
            $display("sparse_set_id_map test failed");
        $finish;
    end

endmodule
